// ===== design/eatrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package eatrm_pkg;

   // Q30 element width: headroom above +/-1 for CORDIC growth and sums.
   localparam int ELEM_W = 34;
   // CORDIC residual angle, degrees times 2^16.
   localparam int ZANG_W = 27;
   localparam int ATAN_W = 23;
   localparam int ATAN_LEN = 24;
   localparam int Q_SHIFT = 30;

   localparam logic signed [ELEM_W-1:0] CORDIC_GAIN = ELEM_W'(652032874);
   localparam logic signed [ELEM_W-1:0] Q_ONE = ELEM_W'(64'sd1 <<< Q_SHIFT);
   localparam logic signed [16:0] NINETY_DEG = 17'sd11520;
   localparam logic signed [16:0] HALF_TURN = 17'sd23040;

   // atan(2^-i) in degrees times 2^16
   localparam logic [ATAN_W-1:0] ATAN_DEG [ATAN_LEN] = '{
      23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
      23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833,
      23'd917, 23'd458, 23'd229, 23'd115, 23'd57, 23'd29,
      23'd14, 23'd7, 23'd4, 23'd2, 23'd1, 23'd0
   };

   // Product order codes
   localparam logic [2:0] ORD_X_Y_Z = 3'd0;
   localparam logic [2:0] ORD_X_Z_Y = 3'd1;
   localparam logic [2:0] ORD_Y_X_Z = 3'd2;
   localparam logic [2:0] ORD_Z_X_Y = 3'd3;
   localparam logic [2:0] ORD_Z_Y_X = 3'd4;
   localparam logic [2:0] ORD_Y_Z_X = 3'd5;

   typedef logic signed [ELEM_W-1:0] elem_type;
   typedef logic [2:0] [2:0] [ELEM_W-1:0] mat_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] x;
      logic signed [ELEM_W-1:0] y;
      logic signed [ZANG_W-1:0] z;
      logic neg;
   } lane_type;

   typedef lane_type [2:0] lane_set_type;

endpackage
`default_nettype wire

// ===== design/eatrm_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module eatrm_cordic_cell #(
   parameter int STAGE = 0
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic up_valid,
   output logic up_ready,
   input wire eatrm_pkg::lane_set_type up_data,
   output logic dn_valid,
   input wire logic dn_ready,
   output eatrm_pkg::lane_set_type dn_data
);

   logic valid_ff;
   eatrm_pkg::lane_set_type data_ff, data_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [eatrm_pkg::ELEM_W-1:0] xs, ys;
         logic signed [eatrm_pkg::ZANG_W-1:0] at;
         xs = up_data[k].x >>> STAGE;
         ys = up_data[k].y >>> STAGE;
         at = eatrm_pkg::ZANG_W'(eatrm_pkg::ATAN_DEG[STAGE]);
         data_in[k].neg = up_data[k].neg;
         if (!up_data[k].z[eatrm_pkg::ZANG_W-1]) begin
            data_in[k].x = up_data[k].x - ys;
            data_in[k].y = up_data[k].y + xs;
            data_in[k].z = up_data[k].z - at;
         end else begin
            data_in[k].x = up_data[k].x + ys;
            data_in[k].y = up_data[k].y - xs;
            data_in[k].z = up_data[k].z + at;
         end
      end
   end

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/eatrm_mat_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module eatrm_mat_mul (
   input wire logic clock,
   input wire logic reset,
   input wire logic up_valid,
   output logic up_ready,
   input wire eatrm_pkg::mat_type a,
   input wire eatrm_pkg::mat_type b,
   output logic dn_valid,
   input wire logic dn_ready,
   output eatrm_pkg::mat_type dn_data
);

   localparam int PW = 2 * eatrm_pkg::ELEM_W;
   localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (eatrm_pkg::Q_SHIFT - 1));

   logic signed [PW-1:0] prod_ff [3][3][3];
   logic prod_valid_ff, sum_valid_ff, prod_ready;
   eatrm_pkg::mat_type sum_ff, sum_in;

   assign prod_ready = !sum_valid_ff || dn_ready;
   assign up_ready = !prod_valid_ff || prod_ready;
   assign dn_valid = sum_valid_ff;
   assign dn_data = sum_ff;

   // stage one: 27 products, each registered
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               for (int k = 0; k < 3; k++) begin
                  prod_ff[i][j][k] <= PW'($signed(a[i][k])) * PW'($signed(b[k][j]));
               end
            end
         end
      end
   end

   // stage two: round each term back to Q30, then add the three
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic signed [PW-1:0] r0, r1, r2;
            r0 = (prod_ff[i][j][0] + HALF) >>> eatrm_pkg::Q_SHIFT;
            r1 = (prod_ff[i][j][1] + HALF) >>> eatrm_pkg::Q_SHIFT;
            r2 = (prod_ff[i][j][2] + HALF) >>> eatrm_pkg::Q_SHIFT;
            sum_in[i][j] = eatrm_pkg::ELEM_W'(r0 + r1 + r2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid_ff) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         if (up_ready) begin
            prod_valid_ff <= up_valid;
         end
         if (prod_ready) begin
            sum_valid_ff <= prod_valid_ff;
         end
      end
   end

endmodule
`default_nettype wire

// ===== design/euler_angles_to_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Euler angles to 3x3 rotation matrix. Each req beat carries three angles in
// degrees times 128; each rsp beat carries the nine matrix elements, row
// first, in signed fixed point with OUTPUT_FRACTION_BITS fraction bits,
// saturated to plus or minus one. A row of CORDIC cells (one cell per
// iteration, all three angles side by side) finds sine and cosine, then two
// matrix multipliers (products, then rounded sums) form the product in the
// order held in the csr register (reset: Z*Y*X; codes 6 and 7 give the
// identity). A new beat is taken every cycle while rsp is not stalled.
// Every stage holds its own valid bit, so bubbles close up while rsp is
// stalled. Write csr only while no beat is in flight.
module euler_angles_to_rotation_matrix_unit #(
   parameter int CORDIC_STAGES = 16,
   parameter int OUTPUT_FRACTION_BITS = 14
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_tvalid,
   output logic req_tready,
   // angle_x [15:0], angle_y [31:16], angle_z [47:32]
   input wire logic [47:0] req_tdata,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   // m00 [15:0], m01, m02, m10, m11, m12, m20, m21, m22 [143:128]
   output logic [143:0] rsp_tdata,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [2:0] csr_data
);

   localparam int EW = eatrm_pkg::ELEM_W;
   localparam int NST = (CORDIC_STAGES < eatrm_pkg::ATAN_LEN) ? CORDIC_STAGES
                                                                : eatrm_pkg::ATAN_LEN;
   localparam int SH = eatrm_pkg::Q_SHIFT - OUTPUT_FRACTION_BITS;
   localparam logic signed [EW:0] RND = (SH > 0) ? (EW + 1)'(64'sd1 <<< (SH - 1))
                                                 : (EW + 1)'(0);
   localparam logic signed [EW:0] LIM = (EW + 1)'(64'sd1 <<< OUTPUT_FRACTION_BITS);

   logic [2:0] order_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= eatrm_pkg::ORD_Z_Y_X;
      end else if (csr_valid && csr_ready) begin
         order_ff <= csr_data;
      end
   end

   // Fold angles beyond ninety degrees by half a turn and mark them for negation
   eatrm_pkg::lane_set_type chain_data [NST+1];
   logic chain_valid [NST+1];
   logic chain_ready [NST+1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic signed [16:0] ang;
         ang = 17'($signed(req_tdata[16*k +: 16]));
         chain_data[0][k].neg = 1'b0;
         if (ang > eatrm_pkg::NINETY_DEG) begin
            ang = ang - eatrm_pkg::HALF_TURN;
            chain_data[0][k].neg = 1'b1;
         end else if (ang < -eatrm_pkg::NINETY_DEG) begin
            ang = ang + eatrm_pkg::HALF_TURN;
            chain_data[0][k].neg = 1'b1;
         end
         chain_data[0][k].x = eatrm_pkg::CORDIC_GAIN;
         chain_data[0][k].y = '0;
         chain_data[0][k].z = eatrm_pkg::ZANG_W'(ang) <<< 9;
      end
   end

   assign chain_valid[0] = req_tvalid;
   assign req_tready = chain_ready[0];

   for (genvar g = 0; g < NST; g++) begin : g_cell
      eatrm_cordic_cell #(.STAGE(g)) u_cell (
         .clock(clock),
         .reset(reset),
         .up_valid(chain_valid[g]),
         .up_ready(chain_ready[g]),
         .up_data(chain_data[g]),
         .dn_valid(chain_valid[g+1]),
         .dn_ready(chain_ready[g+1]),
         .dn_data(chain_data[g+1])
      );
   end

   // Build the elementary rotations and pick the operands for the order
   eatrm_pkg::elem_type s_v [3], c_v [3];
   eatrm_pkg::mat_type rx, ry, rz, idm, op_a, op_b, op_c;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s_v[k] = chain_data[NST][k].neg ? -chain_data[NST][k].y : chain_data[NST][k].y;
         c_v[k] = chain_data[NST][k].neg ? -chain_data[NST][k].x : chain_data[NST][k].x;
      end
      idm = '0;
      idm[0][0] = eatrm_pkg::Q_ONE;
      idm[1][1] = eatrm_pkg::Q_ONE;
      idm[2][2] = eatrm_pkg::Q_ONE;
      rx = idm;
      rx[1][1] = c_v[0]; rx[1][2] = -s_v[0]; rx[2][1] = s_v[0]; rx[2][2] = c_v[0];
      ry = idm;
      ry[0][0] = c_v[1]; ry[0][2] = s_v[1]; ry[2][0] = -s_v[1]; ry[2][2] = c_v[1];
      rz = idm;
      rz[0][0] = c_v[2]; rz[0][1] = -s_v[2]; rz[1][0] = s_v[2]; rz[1][1] = c_v[2];
      unique case (order_ff)
         eatrm_pkg::ORD_X_Y_Z: begin op_a = rx; op_b = ry; op_c = rz; end
         eatrm_pkg::ORD_X_Z_Y: begin op_a = rx; op_b = rz; op_c = ry; end
         eatrm_pkg::ORD_Y_X_Z: begin op_a = ry; op_b = rx; op_c = rz; end
         eatrm_pkg::ORD_Z_X_Y: begin op_a = rz; op_b = rx; op_c = ry; end
         eatrm_pkg::ORD_Z_Y_X: begin op_a = rz; op_b = ry; op_c = rx; end
         eatrm_pkg::ORD_Y_Z_X: begin op_a = ry; op_b = rz; op_c = rx; end
         default: begin op_a = idm; op_b = idm; op_c = idm; end
      endcase
   end

   // Hold the third operand alongside the first product: it travels a
   // parallel path with the same depth
   logic m1_valid, m1_ready, m2_valid, m2_ready;
   eatrm_pkg::mat_type m1_data, m2_data;
   eatrm_pkg::mat_type c_d1_ff, c_d2_ff;
   logic m1_up_ready;

   eatrm_mat_mul u_mul_first (
      .clock(clock),
      .reset(reset),
      .up_valid(chain_valid[NST]),
      .up_ready(m1_up_ready),
      .a(op_a),
      .b(op_b),
      .dn_valid(m1_valid),
      .dn_ready(m1_ready),
      .dn_data(m1_data)
   );

   assign chain_ready[NST] = m1_up_ready;

   // Advance the delayed operand exactly as the first multiplier's two stages
   always_ff @(posedge clock) begin
      if (m1_up_ready && chain_valid[NST]) begin
         c_d1_ff <= op_c;
      end
      if ((!m1_valid || m1_ready) && u_mul_first.prod_valid_ff) begin
         c_d2_ff <= c_d1_ff;
      end
   end

   eatrm_mat_mul u_mul_second (
      .clock(clock),
      .reset(reset),
      .up_valid(m1_valid),
      .up_ready(m1_ready),
      .a(m1_data),
      .b(c_d2_ff),
      .dn_valid(m2_valid),
      .dn_ready(m2_ready),
      .dn_data(m2_data)
   );

   // Output register: round from Q30, saturate, keep the low 16 bits
   logic rsp_valid_ff;
   logic [143:0] rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            logic signed [EW:0] v;
            v = ((EW + 1)'($signed(m2_data[i][j])) + RND) >>> SH;
            if (v > LIM) begin
               v = LIM;
            end else if (v < -LIM) begin
               v = -LIM;
            end
            rsp_data_in[16*(3*i+j) +: 16] = v[15:0];
         end
      end
   end

   assign m2_ready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (m2_ready) begin
         rsp_valid_ff <= m2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (m2_ready && m2_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An empty output register lets every stage advance, so req must be open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready) else $error("req stalled with empty output");

   // Reset leaves no beat in the pipeline
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff) else $error("rsp valid straight after reset");

   // Unused order codes give an exact identity; the check covers m00 and m01
   a_identity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && order_ff != eatrm_pkg::ORD_X_Y_Z && order_ff != eatrm_pkg::ORD_X_Z_Y
       && order_ff != eatrm_pkg::ORD_Y_X_Z && order_ff != eatrm_pkg::ORD_Z_X_Y
       && order_ff != eatrm_pkg::ORD_Z_Y_X && order_ff != eatrm_pkg::ORD_Y_Z_X)
      |-> (rsp_data_ff[31:16] == 16'd0 && rsp_data_ff[15:0] == LIM[15:0]))
      else $error("identity order gave a non-identity element");

endmodule
`default_nettype wire
